@@ src/s2i_pkg.sv @@
// Package for the string-to-signed-integer converter.
// Holds the shared types, character codes, status codes and the digit decoder.
// Used by every module in src; depends on nothing.
`default_nettype none

package s2i_pkg;

   localparam longint unsigned MAX_OFFSET = 64'd65535;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [6:0] DIGIT_NONE = 7'd99;
   localparam logic [5:0] BASE_AUTO  = 6'd0;
   localparam logic [5:0] BASE_ONE   = 6'd1;
   localparam logic [5:0] BASE_OCT   = 6'd8;
   localparam logic [5:0] BASE_DEC   = 6'd10;
   localparam logic [5:0] BASE_HEX   = 6'd16;
   localparam logic [5:0] BASE_MAX   = 6'd36;

   localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] VALUE_MIN = 64'h8000_0000_0000_0000;
   localparam logic [15:0] OFFSET_CLIP = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NO_DIGITS,
      STATUS_RANGE,
      STATUS_BAD_BASE
   } s2i_status_type;

   typedef enum logic [2:0] {
      PHASE_DONE,
      PHASE_SPACE,
      PHASE_FIRST,
      PHASE_ZERO,
      PHASE_XSEEN,
      PHASE_DIGITS
   } s2i_phase_type;

   typedef struct packed {
      logic       valid;
      logic       string_start;
      logic [7:0] char_code;
   } s2i_item_type;

   typedef struct packed {
      logic [63:0]    parsed_value;
      logic [15:0]    end_offset;
      s2i_status_type parse_status;
   } s2i_result_type;

   function automatic logic [6:0] digit_value(input logic [7:0] c);
      logic [6:0] d;
      d = DIGIT_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 7'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = 7'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = 7'(c - 8'h61 + 8'd10);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

@@ src/s2i_in_stage.sv @@
// Input register of the string-to-signed-integer converter.
// Holds one accepted character until the parser takes it; uses s2i_pkg.
`default_nettype none

module s2i_in_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_string_start,
   input  wire logic [7:0]          req_char_code,
   input  wire logic                advance,
   output s2i_pkg::s2i_item_type    item
);

   logic       valid_ff, valid_in;
   logic       start_ff;
   logic [7:0] char_ff;

   assign req_stall = valid_ff & ~advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         start_ff <= req_string_start;
         char_ff  <= req_char_code;
      end
   end

   assign item.valid        = valid_ff;
   assign item.string_start = start_ff;
   assign item.char_code    = char_ff;

endmodule

`default_nettype wire

@@ src/s2i_core.sv @@
// Parser core of the string-to-signed-integer converter: base register, parse state,
// one multiply-add per character with saturation. Uses s2i_pkg.
`default_nettype none

module s2i_core #(
   parameter longint unsigned MAX_OFFSET = s2i_pkg::MAX_OFFSET
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [5:0]            csr_wr_data,
   input  wire s2i_pkg::s2i_item_type item,
   input  wire logic                  advance,
   output logic                       emit,
   output s2i_pkg::s2i_result_type    result
);

   localparam int PosW = $clog2(MAX_OFFSET + 1);
   localparam int ExtW = (PosW > 16) ? PosW : 16;

   logic [5:0]             number_base_ff;
   s2i_pkg::s2i_phase_type phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [63:0]            acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic                   seen_ff, seen_in;
   logic [5:0]             base_ff, base_in;
   logic [PosW-1:0]        pos_ff, pos_in;
   logic [PosW-1:0]        zeo_ff, zeo_in;

   logic [7:0]             c;
   logic [6:0]             dv;
   logic                   is_space;
   logic                   do_first;
   logic                   do_digit;
   logic [69:0]            sum;
   logic [69:0]            limit;
   logic [PosW-1:0]        pos_cur;
   logic [PosW-1:0]        emit_pos;
   logic [ExtW-1:0]        pos_ext;

   assign c        = item.char_code;
   assign dv       = s2i_pkg::digit_value(c);
   assign is_space = (c == s2i_pkg::CHAR_SPACE) ||
                     (c >= s2i_pkg::CHAR_TAB && c <= s2i_pkg::CHAR_CR);

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      base_in  = base_ff;
      pos_in   = pos_ff;
      zeo_in   = zeo_ff;
      emit     = 1'b0;
      do_first = 1'b0;
      do_digit = 1'b0;
      emit_pos = '0;
      sum      = '0;
      limit    = '0;
      pos_cur  = pos_ff;
      result.parsed_value = '0;
      result.end_offset   = '0;
      result.parse_status = s2i_pkg::STATUS_OK;

      if (advance) begin
         if (item.string_start) begin
            base_in  = number_base_ff;
            neg_in   = 1'b0;
            acc_in   = '0;
            ovf_in   = 1'b0;
            seen_in  = 1'b0;
            pos_in   = '0;
            zeo_in   = '0;
            phase_in = s2i_pkg::PHASE_SPACE;
            pos_cur  = '0;
         end

         if (item.string_start &&
             (base_in == s2i_pkg::BASE_ONE || base_in > s2i_pkg::BASE_MAX)) begin
            emit                = 1'b1;
            result.parse_status = s2i_pkg::STATUS_BAD_BASE;
            phase_in            = s2i_pkg::PHASE_DONE;
         end else if (phase_in != s2i_pkg::PHASE_DONE) begin
            case (phase_in)
               s2i_pkg::PHASE_SPACE: begin
                  if (is_space) begin
                     phase_in = s2i_pkg::PHASE_SPACE;
                  end else if (c == s2i_pkg::CHAR_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = s2i_pkg::PHASE_FIRST;
                  end else if (c == s2i_pkg::CHAR_PLUS) begin
                     phase_in = s2i_pkg::PHASE_FIRST;
                  end else begin
                     do_first = 1'b1;
                  end
               end
               s2i_pkg::PHASE_FIRST: begin
                  do_first = 1'b1;
               end
               s2i_pkg::PHASE_ZERO: begin
                  if (c == s2i_pkg::CHAR_LOW_X || c == s2i_pkg::CHAR_UP_X) begin
                     phase_in = s2i_pkg::PHASE_XSEEN;
                  end else begin
                     if (base_in == s2i_pkg::BASE_AUTO) begin
                        base_in = s2i_pkg::BASE_OCT;
                     end
                     do_digit = 1'b1;
                  end
               end
               s2i_pkg::PHASE_XSEEN: begin
                  if (dv < 7'(s2i_pkg::BASE_HEX)) begin
                     base_in  = s2i_pkg::BASE_HEX;
                     do_digit = 1'b1;
                  end else begin
                     emit     = 1'b1;
                     emit_pos = zeo_ff;
                     phase_in = s2i_pkg::PHASE_DONE;
                  end
               end
               default: begin
                  do_digit = 1'b1;
               end
            endcase

            if (do_first) begin
               if (c == s2i_pkg::CHAR_ZERO &&
                   (base_in == s2i_pkg::BASE_AUTO || base_in == s2i_pkg::BASE_HEX)) begin
                  seen_in  = 1'b1;
                  acc_in   = '0;
                  zeo_in   = (pos_cur < PosW'(MAX_OFFSET)) ? pos_cur + 1'b1
                                                            : PosW'(MAX_OFFSET);
                  phase_in = s2i_pkg::PHASE_ZERO;
               end else begin
                  if (base_in == s2i_pkg::BASE_AUTO) begin
                     base_in = s2i_pkg::BASE_DEC;
                  end
                  do_digit = 1'b1;
               end
            end

            if (do_digit) begin
               phase_in = s2i_pkg::PHASE_DIGITS;
               limit    = neg_in ? 70'(s2i_pkg::VALUE_MIN) : 70'(s2i_pkg::VALUE_MAX);
               sum      = 70'(acc_in) * 70'(base_in) + 70'(dv);
               if (dv < 7'(base_in)) begin
                  if (!ovf_in) begin
                     if (sum > limit) begin
                        ovf_in = 1'b1;
                     end else begin
                        acc_in = sum[63:0];
                     end
                  end
                  seen_in = 1'b1;
               end else begin
                  emit     = 1'b1;
                  phase_in = s2i_pkg::PHASE_DONE;
                  if (!seen_in) begin
                     result.parse_status = s2i_pkg::STATUS_NO_DIGITS;
                  end else if (ovf_in) begin
                     emit_pos            = pos_cur;
                     result.parsed_value = neg_in ? s2i_pkg::VALUE_MIN : s2i_pkg::VALUE_MAX;
                     result.parse_status = s2i_pkg::STATUS_RANGE;
                  end else begin
                     emit_pos            = pos_cur;
                     result.parsed_value = neg_in ? (64'd0 - acc_in) : acc_in;
                  end
               end
            end

            if (pos_cur < PosW'(MAX_OFFSET)) begin
               pos_in = pos_cur + 1'b1;
            end
         end
      end

      pos_ext           = ExtW'(emit_pos);
      result.end_offset = (pos_ext > ExtW'(s2i_pkg::OFFSET_CLIP)) ? s2i_pkg::OFFSET_CLIP
                                                                   : pos_ext[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= '0;
      end else if (csr_wr_en) begin
         number_base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= s2i_pkg::PHASE_DONE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         base_ff  <= '0;
         pos_ff   <= '0;
         zeo_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         base_ff  <= base_in;
         pos_ff   <= pos_in;
         zeo_ff   <= zeo_in;
      end
   end

endmodule

`default_nettype wire

@@ src/s2i_out_stage.sv @@
// Result register of the string-to-signed-integer converter.
// Holds one result until the receiver takes it; uses s2i_pkg.
`default_nettype none

module s2i_out_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire s2i_pkg::s2i_result_type result,
   output logic                         slot_free,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [63:0]                  rsp_parsed_value,
   output logic [15:0]                  rsp_end_offset,
   output logic [1:0]                   rsp_parse_status
);

   logic                    valid_ff, valid_in;
   s2i_pkg::s2i_result_type result_ff;

   assign slot_free = ~valid_ff | ~rsp_stall;
   assign valid_in  = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_parsed_value = result_ff.parsed_value;
   assign rsp_end_offset   = result_ff.end_offset;
   assign rsp_parse_status = result_ff.parse_status;

endmodule

`default_nettype wire

@@ src/string_to_signed_integer.sv @@
// Top level of the streaming string-to-signed-integer converter.
// Instantiates s2i_in_stage, s2i_core and s2i_out_stage; uses s2i_pkg.
//
// One character enters per req_ transfer; req_string_start marks the first character
// of a string. After leading whitespace, an optional sign and an optional base prefix,
// digits are accumulated with saturation. The first character that is not a digit ends
// the number and produces one rsp_ transfer with the value, the end offset and a status.
// An invalid base gives its result on the string start character.
// The radix is written through csr_wr_en and csr_wr_data and is taken at each string start.
// The ending character is held in the input register; its result is registered for rsp_valid.
// Throughput is one character per cycle while rsp_stall holds no result, set by the single
// multiply-add by the radix between the input register and the result register.
// Reset clears both stages, the parse state and the radix to automatic detection.
// While rsp_stall holds a result, the input register still takes one more character and
// then raises req_stall until the result leaves.
`default_nettype none

module string_to_signed_integer #(
   parameter longint unsigned MAX_OFFSET = s2i_pkg::MAX_OFFSET
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_string_start,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_parsed_value,
   output logic [15:0]      rsp_end_offset,
   output logic [1:0]       rsp_parse_status
);

   s2i_pkg::s2i_item_type   item;
   s2i_pkg::s2i_result_type result;
   logic                    advance;
   logic                    emit;
   logic                    slot_free;

   assign advance = item.valid & slot_free;

   s2i_in_stage u_in_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_string_start (req_string_start),
      .req_char_code    (req_char_code),
      .advance          (advance),
      .item             (item)
   );

   s2i_core #(
      .MAX_OFFSET (MAX_OFFSET)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .advance     (advance),
      .emit        (emit),
      .result      (result)
   );

   s2i_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .load             (emit),
      .result           (result),
      .slot_free        (slot_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_parse_status (rsp_parse_status)
   );

endmodule

`default_nettype wire
